// ----- hdl/iirf_pkg.sv -----
// Shared constants, payload types, microcode types and arithmetic helpers of the IIR filter.
package iirf_pkg;

  localparam int LANES   = 4;
  localparam int FF_TAPS = 4;
  localparam int FB_TAPS = 3;

  localparam int SMP_W      = 16;
  localparam int FRAC       = 14;
  localparam int PROD_W     = 2 * SMP_W;
  localparam int ACC_W      = PROD_W + 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int FB_DEPTH = (FB_TAPS > 0) ? FB_TAPS : 1;
  localparam bit HAS_FB   = (FB_TAPS > 0);
  localparam int TAP_N    = (FF_TAPS > FB_DEPTH) ? FF_TAPS : FB_DEPTH;
  localparam int TAP_W    = (TAP_N > 1) ? $clog2(TAP_N) : 1;
  localparam int LANE_W   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int PC_W     = 4;

  localparam logic [TAP_W-1:0]  FF_LAST   = TAP_W'(FF_TAPS - 1);
  localparam logic [TAP_W-1:0]  FB_LAST   = TAP_W'(FB_DEPTH - 1);
  localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(LANES - 1);

  localparam logic signed [ACC_W:0] SAT_MAX =
    {{(ACC_W + 1 - SMP_W){1'b0}}, 1'b0, {(SMP_W - 1){1'b1}}};
  localparam logic signed [ACC_W:0] SAT_MIN =
    {{(ACC_W + 1 - SMP_W){1'b1}}, 1'b1, {(SMP_W - 1){1'b0}}};
  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W + 1)'(2 ** (FRAC - 1));

  localparam logic signed [SMP_W-1:0] COEF_ONE = SMP_W'(2 ** FRAC);

  typedef logic signed [SMP_W-1:0] smp_t;

  typedef struct packed {
    smp_t sample_lane0;
    smp_t sample_lane1;
    smp_t sample_lane2;
    smp_t sample_lane3;
  } in_item_t;

  typedef struct packed {
    smp_t filtered_lane0;
    smp_t filtered_lane1;
    smp_t filtered_lane2;
    smp_t filtered_lane3;
    logic saturated;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF_COEF_0 = 3'd0,
    REG_FF_COEF_1 = 3'd1,
    REG_FF_COEF_2 = 3'd2,
    REG_FF_COEF_3 = 3'd3,
    REG_OUT_GAIN  = 3'd4,
    REG_FB_COEF_1 = 3'd5,
    REG_FB_COEF_2 = 3'd6,
    REG_FB_COEF_3 = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_LOAD,
    OP_MAC_FF,
    OP_MAC_FB,
    OP_RND1,
    OP_GAIN,
    OP_RND2,
    OP_PUSH
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_FF_MORE,
    C_FB_MORE,
    C_LANE_MORE,
    C_OUT_BUSY
  } cond_t;

  localparam logic [PC_W-1:0] UC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] UC_LOAD = 4'd1;
  localparam logic [PC_W-1:0] UC_FF   = 4'd2;
  localparam logic [PC_W-1:0] UC_FB   = 4'd3;
  localparam logic [PC_W-1:0] UC_RND1 = 4'd4;
  localparam logic [PC_W-1:0] UC_GAIN = 4'd5;
  localparam logic [PC_W-1:0] UC_RND2 = 4'd6;
  localparam logic [PC_W-1:0] UC_PUSH = 4'd7;
  localparam logic [PC_W-1:0] UC_END  = 4'd8;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ucw_t;

  typedef struct packed {
    op_t               op;
    logic              fire;
    logic [LANE_W-1:0] lane;
    logic [TAP_W-1:0]  tap;
  } ctl_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic clip;
    smp_t val;
  } rs_t;

  function automatic rs_t round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] v;
    logic signed [ACC_W:0] q;
    rs_t r;
    v = (ACC_W + 1)'(acc) + RND_HALF;
    q = v >>> FRAC;
    if (q > SAT_MAX) begin
      r.clip = 1'b1;
      r.val  = SAT_MAX[SMP_W-1:0];
    end else if (q < SAT_MIN) begin
      r.clip = 1'b1;
      r.val  = SAT_MIN[SMP_W-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = q[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/iirf_ucode_rom.sv -----
// Read-only microcode store: one control word per program step.
module iirf_ucode_rom (
  input  logic [iirf_pkg::PC_W-1:0] pc,
  output iirf_pkg::ucw_t            word
);

  always_comb begin
    unique case (pc)
      iirf_pkg::UC_IDLE: word = '{iirf_pkg::OP_TAKE,   iirf_pkg::C_NO_IN,     iirf_pkg::UC_IDLE};
      iirf_pkg::UC_LOAD: word = '{iirf_pkg::OP_LOAD,   iirf_pkg::C_NEVER,     iirf_pkg::UC_IDLE};
      iirf_pkg::UC_FF:   word = '{iirf_pkg::OP_MAC_FF, iirf_pkg::C_FF_MORE,   iirf_pkg::UC_FF};
      iirf_pkg::UC_FB:   word = '{iirf_pkg::OP_MAC_FB, iirf_pkg::C_FB_MORE,   iirf_pkg::UC_FB};
      iirf_pkg::UC_RND1: word = '{iirf_pkg::OP_RND1,   iirf_pkg::C_NEVER,     iirf_pkg::UC_IDLE};
      iirf_pkg::UC_GAIN: word = '{iirf_pkg::OP_GAIN,   iirf_pkg::C_NEVER,     iirf_pkg::UC_IDLE};
      iirf_pkg::UC_RND2: word = '{iirf_pkg::OP_RND2,   iirf_pkg::C_LANE_MORE, iirf_pkg::UC_LOAD};
      iirf_pkg::UC_PUSH: word = '{iirf_pkg::OP_PUSH,   iirf_pkg::C_OUT_BUSY,  iirf_pkg::UC_PUSH};
      iirf_pkg::UC_END:  word = '{iirf_pkg::OP_NOP,    iirf_pkg::C_ALWAYS,    iirf_pkg::UC_IDLE};
      default:           word = '{iirf_pkg::OP_NOP,    iirf_pkg::C_ALWAYS,    iirf_pkg::UC_IDLE};
    endcase
  end

endmodule

// ----- hdl/iirf_seq.sv -----
// Microcode sequencer: program counter, lane and tap counters, jump conditions.
module iirf_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  iirf_pkg::sts_t sts,
  output iirf_pkg::ctl_t ctl
);

  logic [iirf_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic [iirf_pkg::LANE_W-1:0] lane_r, lane_nxt;
  logic [iirf_pkg::TAP_W-1:0]  tap_r, tap_nxt;
  iirf_pkg::ucw_t              word;
  logic                        jump;

  iirf_ucode_rom u_rom (
    .pc   (pc_r),
    .word (word)
  );

  always_comb begin
    unique case (word.cond)
      iirf_pkg::C_NEVER:     jump = 1'b0;
      iirf_pkg::C_ALWAYS:    jump = 1'b1;
      iirf_pkg::C_NO_IN:     jump = !in_valid;
      iirf_pkg::C_FF_MORE:   jump = (tap_r != iirf_pkg::FF_LAST);
      iirf_pkg::C_FB_MORE:   jump = (tap_r != iirf_pkg::FB_LAST);
      iirf_pkg::C_LANE_MORE: jump = (lane_r != iirf_pkg::LANE_LAST);
      iirf_pkg::C_OUT_BUSY:  jump = sts.out_busy;
      default:               jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt   = jump ? word.target : pc_r + iirf_pkg::PC_W'(1);
    lane_nxt = lane_r;
    tap_nxt  = tap_r;
    unique case (word.op)
      iirf_pkg::OP_TAKE: begin
        lane_nxt = '0;
        tap_nxt  = '0;
      end
      iirf_pkg::OP_MAC_FF, iirf_pkg::OP_MAC_FB: begin
        tap_nxt = jump ? tap_r + iirf_pkg::TAP_W'(1) : '0;
      end
      iirf_pkg::OP_RND2: begin
        lane_nxt = jump ? lane_r + iirf_pkg::LANE_W'(1) : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= iirf_pkg::UC_IDLE;
      lane_r <= '0;
      tap_r  <= '0;
    end else begin
      pc_r   <= pc_nxt;
      lane_r <= lane_nxt;
      tap_r  <= tap_nxt;
    end
  end

  always_comb begin
    ctl.op   = word.op;
    ctl.lane = lane_r;
    ctl.tap  = tap_r;
    unique case (word.op)
      iirf_pkg::OP_TAKE: ctl.fire = in_valid;
      iirf_pkg::OP_PUSH: ctl.fire = !sts.out_busy;
      default:           ctl.fire = 1'b1;
    endcase
  end

`ifndef SYNTHESIS
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= iirf_pkg::UC_END)
    else $error("program counter left the microcode program");

  a_take_load: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == iirf_pkg::UC_IDLE && in_valid) |=> pc_r == iirf_pkg::UC_LOAD)
    else $error("accepted transaction did not start the lane loop");

  a_ff_tap: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == iirf_pkg::UC_FF |-> {1'b0, tap_r} < (iirf_pkg::TAP_W + 1)'(iirf_pkg::FF_TAPS))
    else $error("feedforward tap counter out of range");

  a_lane_done: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == iirf_pkg::UC_RND2 && lane_r == iirf_pkg::LANE_LAST)
      |=> (pc_r == iirf_pkg::UC_PUSH && lane_r == '0))
    else $error("lane loop did not end after the last lane");
`endif

endmodule

// ----- hdl/iirf_dp.sv -----
// Datapath: coefficient registers, lane histories, multiply-accumulate, rounding and result register.
module iirf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  iirf_pkg::ctl_t                    ctl,
  input  iirf_pkg::in_item_t                in_data,
  input  logic                              cfg_we,
  input  logic [iirf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iirf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              out_stall,
  output logic                              out_valid,
  output iirf_pkg::out_item_t               out_data,
  output iirf_pkg::sts_t                    sts
);

  iirf_pkg::smp_t ff_coef_r [iirf_pkg::FF_TAPS];
  iirf_pkg::smp_t fb_coef_r [3];
  iirf_pkg::smp_t gain_r;
  iirf_pkg::smp_t ff_reg_r  [4];

  iirf_pkg::smp_t smp_r  [iirf_pkg::LANES];
  iirf_pkg::smp_t x_hist_r [iirf_pkg::LANES][iirf_pkg::FF_TAPS];
  iirf_pkg::smp_t y_hist_r [iirf_pkg::LANES][iirf_pkg::FB_DEPTH];
  iirf_pkg::smp_t y_r    [iirf_pkg::LANES];
  iirf_pkg::smp_t s_r;
  logic           clip_r;

  logic signed [iirf_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [iirf_pkg::PROD_W-1:0] prod;
  iirf_pkg::smp_t                     mul_a, mul_b;
  iirf_pkg::rs_t                      rs;

  logic                out_valid_r;
  iirf_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_reg_r[0] <= iirf_pkg::COEF_ONE;
      ff_reg_r[1] <= '0;
      ff_reg_r[2] <= '0;
      ff_reg_r[3] <= '0;
      gain_r      <= iirf_pkg::COEF_ONE;
      fb_coef_r[0] <= '0;
      fb_coef_r[1] <= '0;
      fb_coef_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (iirf_pkg::cfg_reg_t'(cfg_index))
        iirf_pkg::REG_FF_COEF_0: ff_reg_r[0]  <= cfg_wdata;
        iirf_pkg::REG_FF_COEF_1: ff_reg_r[1]  <= cfg_wdata;
        iirf_pkg::REG_FF_COEF_2: ff_reg_r[2]  <= cfg_wdata;
        iirf_pkg::REG_FF_COEF_3: ff_reg_r[3]  <= cfg_wdata;
        iirf_pkg::REG_OUT_GAIN:  gain_r       <= cfg_wdata;
        iirf_pkg::REG_FB_COEF_1: fb_coef_r[0] <= cfg_wdata;
        iirf_pkg::REG_FB_COEF_2: fb_coef_r[1] <= cfg_wdata;
        iirf_pkg::REG_FB_COEF_3: fb_coef_r[2] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < iirf_pkg::FF_TAPS; k++) begin
      ff_coef_r[k] = ff_reg_r[k];
    end
  end

  always_comb begin
    unique case (ctl.op)
      iirf_pkg::OP_MAC_FF: begin
        mul_a = ff_coef_r[ctl.tap];
        mul_b = x_hist_r[ctl.lane][ctl.tap];
      end
      iirf_pkg::OP_MAC_FB: begin
        mul_a = fb_coef_r[ctl.tap];
        mul_b = y_hist_r[ctl.lane][ctl.tap];
      end
      default: begin
        mul_a = gain_r;
        mul_b = s_r;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign rs   = iirf_pkg::round_sat(acc_r);

  always_comb begin
    unique case (ctl.op)
      iirf_pkg::OP_LOAD:   acc_nxt = '0;
      iirf_pkg::OP_MAC_FF: acc_nxt = acc_r + iirf_pkg::ACC_W'(prod);
      iirf_pkg::OP_MAC_FB: acc_nxt = iirf_pkg::HAS_FB ? acc_r - iirf_pkg::ACC_W'(prod) : acc_r;
      iirf_pkg::OP_GAIN:   acc_nxt = iirf_pkg::ACC_W'(prod);
      default:             acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (ctl.op == iirf_pkg::OP_TAKE && ctl.fire) begin
      smp_r[0] <= in_data.sample_lane0;
      smp_r[1] <= in_data.sample_lane1;
      smp_r[2] <= in_data.sample_lane2;
      smp_r[3] <= in_data.sample_lane3;
    end
    if (ctl.op == iirf_pkg::OP_RND1) begin
      s_r <= rs.val;
    end
    if (ctl.op == iirf_pkg::OP_RND2) begin
      y_r[ctl.lane] <= rs.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= 1'b0;
      for (int l = 0; l < iirf_pkg::LANES; l++) begin
        for (int k = 0; k < iirf_pkg::FF_TAPS; k++) begin
          x_hist_r[l][k] <= '0;
        end
        for (int k = 0; k < iirf_pkg::FB_DEPTH; k++) begin
          y_hist_r[l][k] <= '0;
        end
      end
    end else begin
      unique case (ctl.op)
        iirf_pkg::OP_TAKE: clip_r <= 1'b0;
        iirf_pkg::OP_LOAD: begin
          for (int k = iirf_pkg::FF_TAPS - 1; k > 0; k--) begin
            x_hist_r[ctl.lane][k] <= x_hist_r[ctl.lane][k-1];
          end
          x_hist_r[ctl.lane][0] <= smp_r[ctl.lane];
        end
        iirf_pkg::OP_RND1: clip_r <= clip_r | rs.clip;
        iirf_pkg::OP_RND2: begin
          clip_r <= clip_r | rs.clip;
          for (int k = iirf_pkg::FB_DEPTH - 1; k > 0; k--) begin
            y_hist_r[ctl.lane][k] <= y_hist_r[ctl.lane][k-1];
          end
          y_hist_r[ctl.lane][0] <= rs.val;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.op == iirf_pkg::OP_PUSH && ctl.fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == iirf_pkg::OP_PUSH && ctl.fire) begin
      out_data_r.filtered_lane0 <= y_r[0];
      out_data_r.filtered_lane1 <= y_r[1];
      out_data_r.filtered_lane2 <= y_r[2];
      out_data_r.filtered_lane3 <= y_r[3];
      out_data_r.saturated      <= clip_r;
    end
  end

  assign sts.out_busy = out_valid_r && out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

`ifndef SYNTHESIS
  a_push_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == iirf_pkg::OP_PUSH && ctl.fire) |=> out_valid_r)
    else $error("pushed result did not appear on the output");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == iirf_pkg::OP_PUSH && ctl.fire) |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while still held");

  a_take_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == iirf_pkg::OP_TAKE && ctl.fire) |=> !clip_r)
    else $error("clipping flag not cleared at the start of a transaction");
`endif

endmodule

// ----- hdl/multichannel_iir_filter.sv -----
// Top level of the multichannel direct-form-I IIR filter with microcoded control.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    in_data   (iirf_pkg::in_item_t)
//   out_     output     out_valid / out_stall  out_data  (iirf_pkg::out_item_t)
//   cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// A transaction runs from acceptance to the next acceptance with the single shared
// multiplier stepping through every tap of every lane; no new input is taken before
// the last result is pushed. The result register is loaded in the last steps;
// while it is still held by out_stall the program waits there.
// Reset is synchronous: it clears the histories and restores the default coefficients.
module multichannel_iir_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  iirf_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output iirf_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [iirf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iirf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  iirf_pkg::ctl_t ctl;
  iirf_pkg::sts_t sts;

  iirf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .ctl      (ctl)
  );

  iirf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .sts       (sts)
  );

  assign in_stall = !rst_n || (ctl.op != iirf_pkg::OP_TAKE);

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench of the multichannel IIR filter with a scoreboard that predicts each filtered vector.
`timescale 1ns / 100ps

module tb_top;
  import iirf_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_VECTORS = 236;

  class iir_scoreboard;
    smp_t      ff_coef [FF_TAPS];
    smp_t      fb_coef [1:3];
    smp_t      out_gain;
    smp_t      x_hist [LANES][FF_TAPS];
    smp_t      y_hist [LANES][FB_DEPTH];
    out_item_t filtered_q [$];
    int        fails;

    function new();
      ff_coef    = '{default: '0};
      fb_coef    = '{default: '0};
      ff_coef[0] = COEF_ONE;
      out_gain   = COEF_ONE;
      x_hist     = '{default: '0};
      y_hist     = '{default: '0};
      fails      = 0;
    endfunction

    function void set_coef(cfg_reg_t r, logic [15:0] v);
      case (r)
        REG_FF_COEF_0: ff_coef[0] = v;
        REG_FF_COEF_1: ff_coef[1] = v;
        REG_FF_COEF_2: ff_coef[2] = v;
        REG_FF_COEF_3: ff_coef[3] = v;
        REG_OUT_GAIN:  out_gain   = v;
        REG_FB_COEF_1: fb_coef[1] = v;
        REG_FB_COEF_2: fb_coef[2] = v;
        REG_FB_COEF_3: fb_coef[3] = v;
        default: ;
      endcase
    endfunction

    // Rounds half up, drops the fraction bits and clips to the sample range.
    function smp_t requantise(longint acc, inout bit clip);
      longint q;
      q = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
      if (q > 32767) begin
        clip = 1'b1;
        return 16'sh7fff;
      end
      if (q < -32768) begin
        clip = 1'b1;
        return 16'sh8000;
      end
      return smp_t'(q);
    endfunction

    function out_item_t filter_lanes(in_item_t item);
      smp_t      x_new [LANES];
      smp_t      y_new [LANES];
      smp_t      s;
      longint    acc;
      bit        clip;
      out_item_t res;
      clip  = 1'b0;
      x_new = '{item.sample_lane0, item.sample_lane1, item.sample_lane2, item.sample_lane3};
      for (int l = 0; l < LANES; l++) begin
        for (int k = FF_TAPS - 1; k > 0; k--) x_hist[l][k] = x_hist[l][k-1];
        x_hist[l][0] = x_new[l];
        acc = 0;
        for (int k = 0; k < FF_TAPS; k++)
          acc += longint'(ff_coef[k]) * longint'(x_hist[l][k]);
        for (int k = 1; k <= FB_TAPS; k++)
          acc -= longint'(fb_coef[k]) * longint'(y_hist[l][k-1]);
        s        = requantise(acc, clip);
        y_new[l] = requantise(longint'(s) * longint'(out_gain), clip);
        if (HAS_FB) begin
          for (int k = FB_DEPTH - 1; k > 0; k--) y_hist[l][k] = y_hist[l][k-1];
          y_hist[l][0] = y_new[l];
        end
      end
      res.filtered_lane0 = y_new[0];
      res.filtered_lane1 = y_new[1];
      res.filtered_lane2 = y_new[2];
      res.filtered_lane3 = y_new[3];
      res.saturated      = clip;
      return res;
    endfunction

    function void take_samples(in_item_t item);
      filtered_q.push_back(filter_lanes(item));
    endfunction

    function void check_filtered(out_item_t got);
      out_item_t   want;
      logic [15:0] w [5];
      logic [15:0] g [5];
      string       names [5];
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected filtered vector %h", $time, got);
        fails++;
        return;
      end
      want  = filtered_q.pop_front();
      names = '{"filtered_lane0", "filtered_lane1", "filtered_lane2", "filtered_lane3",
                "saturated"};
      w = '{want.filtered_lane0, want.filtered_lane1, want.filtered_lane2,
            want.filtered_lane3, {15'd0, want.saturated}};
      g = '{got.filtered_lane0, got.filtered_lane1, got.filtered_lane2,
            got.filtered_lane3, {15'd0, got.saturated}};
      for (int i = 0; i < 5; i++) begin
        if (g[i] !== w[i]) begin
          $display("%0t: %s expected %0d, got %0d", $time, names[i],
                   $signed(w[i]), $signed(g[i]));
          fails++;
        end
      end
    endfunction

    function int pending();
      return filtered_q.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_stall;
  logic                  out_valid;
  out_item_t             out_data;

  iir_scoreboard sb = new();
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int quiet_cycles = 0;

  multichannel_iir_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_filtered(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("[multichannel_iir_filter] ERROR");
      $finish;
    end
  end

  function automatic in_item_t make_vector(smp_t a, smp_t b, smp_t c, smp_t d);
    in_item_t v;
    v.sample_lane0 = a;
    v.sample_lane1 = b;
    v.sample_lane2 = c;
    v.sample_lane3 = d;
    return v;
  endfunction

  function automatic smp_t random_sample();
    smp_t picks [5];
    picks = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001};
    case ($urandom_range(9))
      0:       return picks[$urandom_range(4)];
      1, 2:    return smp_t'(int'($urandom_range(512)) - 256);
      default: return smp_t'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_vector();
    return make_vector(random_sample(), random_sample(), random_sample(), random_sample());
  endfunction

  function automatic void random_config(int kind, output logic [15:0] vals [8]);
    logic [15:0] picks [7];
    picks = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000, 16'h0001, 16'hffff};
    for (int i = 0; i < 8; i++) begin
      case (kind)
        0:       vals[i] = picks[$urandom_range(6)];
        1:       vals[i] = 16'(int'($urandom_range(16384)) - 8192);
        default: vals[i] = 16'($urandom);
      endcase
    end
    // A mild setting keeps the feedback loop stable so that outputs rarely clip.
    if (kind == 1) begin
      vals[REG_OUT_GAIN]  = 16'($urandom_range(16384, 8192));
      vals[REG_FB_COEF_1] = 16'(int'($urandom_range(8192)) - 4096);
      vals[REG_FB_COEF_2] = 16'(int'($urandom_range(8192)) - 4096);
      vals[REG_FB_COEF_3] = 16'(int'($urandom_range(8192)) - 4096);
    end
  endfunction

  task automatic write_reg(cfg_reg_t r, logic [15:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_coef(r, v);
  endtask

  task automatic load_config(input logic [15:0] vals [8]);
    cfg_reg_t r;
    r = r.first();
    repeat (r.num()) begin
      write_reg(r, vals[r]);
      r = r.next();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_vector(in_item_t item);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.take_samples(item);
  endtask

  task automatic drain_filter();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [15:0] cfg_set [8];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    in_idle_pct  = 13;
    out_idle_pct = 75;

    send_vector(make_vector(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
    send_vector(make_vector(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
    send_vector(make_vector(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    send_vector(make_vector(16'sh7fff, 16'sh8000, 16'shffff, 16'sh0001));
    send_vector(make_vector(16'sh5555, 16'shaaaa, 16'sh00ff, 16'shff00));

    // Half weight puts positive and negative ties on the rounding boundary.
    drain_filter();
    cfg_set = '{16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000};
    load_config(cfg_set);
    send_vector(make_vector(16'sh0001, 16'shffff, 16'sh0003, 16'shfffd));
    send_vector(make_vector(16'sh8000, 16'sh7fff, 16'sh0002, 16'shfffe));
    send_vector(make_vector(16'sh0005, 16'shfffb, 16'sh0000, 16'sh0001));

    // Strong feedback and gain drive both stages into clipping.
    drain_filter();
    cfg_set = '{16'h4000, 16'h4000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 16'hc000};
    load_config(cfg_set);
    send_vector(make_vector(16'sh7fff, 16'sh8000, 16'sh0100, 16'shff00));
    send_vector(make_vector(16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000));
    send_vector(make_vector(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
    send_vector(make_vector(16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff));
    send_vector(make_vector(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));

    drain_filter();
    cfg_set = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h0000};
    load_config(cfg_set);
    send_vector(make_vector(16'sh7fff, 16'sh8000, 16'sh4000, 16'shc000));
    send_vector(make_vector(16'sh8000, 16'sh7fff, 16'shc000, 16'sh4000));
    send_vector(make_vector(16'sh7fff, 16'sh7fff, 16'sh0001, 16'shffff));
    send_vector(make_vector(16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000));

    for (int phase = 0; phase < 8; phase++) begin
      drain_filter();
      if (phase < 3) begin
        in_idle_pct  = 13;
        out_idle_pct = 75;
      end else if (phase < 6) begin
        in_idle_pct  = 75;
        out_idle_pct = 13;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      random_config(phase % 3, cfg_set);
      load_config(cfg_set);
      repeat (PHASE_VECTORS) send_vector(random_vector());
    end

    drain_filter();
    if (sb.pending() != 0) begin
      $display("%0t: %0d filtered vectors never arrived", $time, sb.pending());
    end
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("[multichannel_iir_filter] OK");
    end else begin
      $display("[multichannel_iir_filter] ERROR");
    end
    $finish;
  end

endmodule
